@@ sv/mie_pkg.sv @@
`timescale 1ns / 1ps
// Shared types for the modular inverse block: controller states,
// datapath operations and the command/status records between them.
// No dependencies.
package mie_pkg;

    // Fixed field widths of the stream payloads
    localparam int P_BITS   = 32;
    localparam int E_BITS   = 64;
    localparam int IN_BITS  = 128;
    localparam int OUT_BITS = 64;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_START,
        S_MUL_WAIT,
        S_STEP,
        S_DIV_WAIT,
        S_UPDATE,
        S_FINAL_WAIT,
        S_DONE,
        S_ERR
    } state_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_INIT,
        OP_DIV,
        OP_ADVANCE,
        OP_FINAL,
        OP_RESULT,
        OP_ERROR
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic unit_done;
        logic zero_operand;
        logic rem_zero;
    } status_t;

endpackage

@@ sv/mie_divmul.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider with a fused MSB-first multiply-accumulate.
// One quotient bit per cycle; in multiply mode the dividend bits drive the
// accumulator instead. Depends on nothing.
module mie_divmul #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  mul_mode,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    input  logic [DATA_WIDTH-1:0] mcand,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] remainder,
    output logic [DATA_WIDTH-1:0] product
);

    localparam int CW = $clog2(DATA_WIDTH);
    localparam logic [CW-1:0] LAST = CW'(DATA_WIDTH - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  mul_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] div_reg;
    logic [DATA_WIDTH-1:0] mcand_reg;
    logic [DATA_WIDTH-1:0] acc_reg;

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;
    logic                  acc_bit;
    logic [DATA_WIDTH-1:0] rem_step;
    logic [DATA_WIDTH-1:0] acc_step;

    // One restoring step and one Horner step of the product
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DATA_WIDTH-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = (trial >= {1'b0, div_reg});
        rem_step = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        acc_bit  = mul_reg ? quo_reg[DATA_WIDTH-1] : ge;
        acc_step = {acc_reg[DATA_WIDTH-2:0], 1'b0} + (acc_bit ? mcand_reg : '0);
    end

    // Sequence the iterations
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Load operands on start, advance one bit while busy
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mul_reg   <= mul_mode;
            rem_reg   <= '0;
            quo_reg   <= dividend;
            div_reg   <= divisor;
            mcand_reg <= mcand;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], ge};
            acc_reg <= acc_step;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
    assign product   = acc_reg;

endmodule

@@ sv/mie_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: operand, Euclid and coefficient registers, the shared
// divide/multiply unit and the output register. Uses mie_pkg, mie_divmul.
module mie_datapath #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mie_pkg::cmd_t                  cmd,
    output mie_pkg::status_t               status,
    input  logic [mie_pkg::IN_BITS-1:0]    in_data,
    output logic [mie_pkg::OUT_BITS-1:0]   out_data,
    output logic                           out_error
);

    logic [DATA_WIDTH-1:0] pm1_reg;
    logic [DATA_WIDTH-1:0] qm1_reg;
    logic [DATA_WIDTH-1:0] exp_reg;
    logic [DATA_WIDTH-1:0] tot_reg;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] prev_reg;
    logic [DATA_WIDTH-1:0] cur_reg;
    logic [mie_pkg::OUT_BITS-1:0] out_data_reg;
    logic                         out_err_reg;

    logic [mie_pkg::P_BITS-1:0] prime_p;
    logic [mie_pkg::P_BITS-1:0] prime_q;
    logic [mie_pkg::E_BITS-1:0] public_exp;

    logic                  unit_start;
    logic                  unit_mul;
    logic [DATA_WIDTH-1:0] unit_a;
    logic [DATA_WIDTH-1:0] unit_b;
    logic [DATA_WIDTH-1:0] unit_m;
    logic                  unit_done;
    logic [DATA_WIDTH-1:0] unit_rem;
    logic [DATA_WIDTH-1:0] unit_prod;

    // Split the input request into its fields
    assign prime_p    = in_data[mie_pkg::P_BITS-1:0];
    assign prime_q    = in_data[2*mie_pkg::P_BITS-1:mie_pkg::P_BITS];
    assign public_exp = in_data[mie_pkg::IN_BITS-1:2*mie_pkg::P_BITS];

    // Select operands for the shared unit
    always_comb
    begin
        unit_start = 1'b0;
        unit_mul   = 1'b0;
        unit_a     = num_reg;
        unit_b     = den_reg;
        unit_m     = cur_reg;
        case (cmd.op)
            mie_pkg::OP_MUL:
            begin
                unit_start = 1'b1;
                unit_mul   = 1'b1;
                unit_a     = pm1_reg;
                unit_b     = '0;
                unit_m     = qm1_reg;
            end
            mie_pkg::OP_DIV:
            begin
                unit_start = 1'b1;
            end
            mie_pkg::OP_FINAL:
            begin
                unit_start = 1'b1;
                unit_a     = tot_reg + cur_reg;
                unit_b     = tot_reg;
            end
            default:
            begin
                unit_start = 1'b0;
            end
        endcase
    end

    // The product carries quotient * coefficient, so the quotient stays inside
    mie_divmul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (unit_start),
        .mul_mode  (unit_mul),
        .dividend  (unit_a),
        .divisor   (unit_b),
        .mcand     (unit_m),
        .done      (unit_done),
        .remainder (unit_rem),
        .product   (unit_prod)
    );

    // Apply the controller's operation to the registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            mie_pkg::OP_LOAD:
            begin
                pm1_reg <= DATA_WIDTH'(prime_p) - 1'b1;
                qm1_reg <= DATA_WIDTH'(prime_q) - 1'b1;
                exp_reg <= DATA_WIDTH'(public_exp);
            end
            mie_pkg::OP_INIT:
            begin
                tot_reg  <= unit_prod;
                num_reg  <= unit_prod;
                den_reg  <= exp_reg;
                prev_reg <= '0;
                cur_reg  <= DATA_WIDTH'(1);
            end
            mie_pkg::OP_ADVANCE:
            begin
                num_reg  <= den_reg;
                den_reg  <= unit_rem;
                prev_reg <= cur_reg;
                cur_reg  <= prev_reg - unit_prod;
            end
            mie_pkg::OP_RESULT:
            begin
                out_data_reg <= mie_pkg::OUT_BITS'(unit_rem);
                out_err_reg  <= 1'b0;
            end
            mie_pkg::OP_ERROR:
            begin
                out_data_reg <= '0;
                out_err_reg  <= 1'b1;
            end
            default:
            begin
                out_err_reg <= out_err_reg;
            end
        endcase
    end

    // Report to the controller
    always_comb
    begin
        status.unit_done    = unit_done;
        status.zero_operand = (tot_reg == '0) || (den_reg == '0);
        status.rem_zero     = (unit_rem == '0);
    end

    assign out_data  = out_data_reg;
    assign out_error = out_err_reg;

endmodule

@@ sv/mie_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: sequences totient multiply, Euclid steps,
// final reduction and the output handshake. Uses mie_pkg.
module mie_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mie_pkg::status_t  status,
    output mie_pkg::cmd_t     cmd
);

    mie_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mie_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = mie_pkg::S_MUL_START;
            end
            mie_pkg::S_MUL_START:
            begin
                state_next = mie_pkg::S_MUL_WAIT;
            end
            mie_pkg::S_MUL_WAIT:
            begin
                if (status.unit_done)
                    state_next = mie_pkg::S_STEP;
            end
            mie_pkg::S_STEP:
            begin
                if (status.zero_operand)
                    state_next = mie_pkg::S_ERR;
                else
                    state_next = mie_pkg::S_DIV_WAIT;
            end
            mie_pkg::S_DIV_WAIT:
            begin
                if (status.unit_done)
                    state_next = mie_pkg::S_UPDATE;
            end
            mie_pkg::S_UPDATE:
            begin
                if (status.rem_zero)
                    state_next = mie_pkg::S_FINAL_WAIT;
                else
                    state_next = mie_pkg::S_STEP;
            end
            mie_pkg::S_FINAL_WAIT:
            begin
                if (status.unit_done)
                    state_next = mie_pkg::S_DONE;
            end
            mie_pkg::S_DONE, mie_pkg::S_ERR:
            begin
                if (out_free)
                    state_next = mie_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mie_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd.op         = mie_pkg::OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            mie_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = mie_pkg::OP_LOAD;
            end
            mie_pkg::S_MUL_START:
            begin
                cmd.op = mie_pkg::OP_MUL;
            end
            mie_pkg::S_MUL_WAIT:
            begin
                if (status.unit_done)
                    cmd.op = mie_pkg::OP_INIT;
            end
            mie_pkg::S_STEP:
            begin
                if (!status.zero_operand)
                    cmd.op = mie_pkg::OP_DIV;
            end
            mie_pkg::S_UPDATE:
            begin
                if (status.rem_zero)
                    cmd.op = mie_pkg::OP_FINAL;
                else
                    cmd.op = mie_pkg::OP_ADVANCE;
            end
            mie_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    cmd.op         = mie_pkg::OP_RESULT;
                    out_valid_next = 1'b1;
                end
            end
            mie_pkg::S_ERR:
            begin
                if (out_free)
                begin
                    cmd.op         = mie_pkg::OP_ERROR;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd.op = mie_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mie_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // The shared unit finishes only while the controller waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.unit_done |-> (state_reg == mie_pkg::S_MUL_WAIT ||
                              state_reg == mie_pkg::S_DIV_WAIT ||
                              state_reg == mie_pkg::S_FINAL_WAIT))
        else $error("divide/multiply unit finished outside a wait state");

    // An accepted request starts the totient multiply
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == mie_pkg::S_MUL_START))
        else $error("accepted request did not start the multiply");

    // A finished item is presented and the controller goes idle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mie_pkg::S_DONE || state_reg == mie_pkg::S_ERR) && out_free)
        |=> (out_valid_reg && state_reg == mie_pkg::S_IDLE))
        else $error("result not presented after completion");

    // A zero operand always ends in the error path
    a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mie_pkg::S_STEP && status.zero_operand)
        |=> (state_reg == mie_pkg::S_ERR))
        else $error("zero operand did not raise the error result");
`endif

endmodule

@@ sv/modular_inverse_euclid.sv @@
`timescale 1ns / 1ps
// Modular inverse by the extended Euclidean algorithm. A request carries
// primes p and q and exponent e; the block forms g = (p-1)(q-1) modulo
// 2^DATA_WIDTH and returns d = (g + b) mod g, b being the final Bezout
// coefficient, so that e*d = 1 (mod g) when e and g are coprime. When e or g
// is zero the result is zero with tuser set. One request is processed at a
// time; the totient multiply, every Euclid step and the final reduction
// each run through one bit-serial divide/multiply unit that retires one
// quotient bit per cycle. The next request is taken as soon as the output
// register holds the previous result.
// Depends on mie_pkg, mie_ctrl, mie_datapath, mie_divmul.
module modular_inverse_euclid #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [31:0] prime_p, [63:32] prime_q, [127:64] public_exp
    input  logic [mie_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [63:0] private_exp
    output logic [mie_pkg::OUT_BITS-1:0] m_axis_tdata,
    // [0] div_error
    output logic                         m_axis_tuser
);

    mie_pkg::cmd_t    cmd;
    mie_pkg::status_t status;

    mie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mie_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .out_error (m_axis_tuser)
    );

endmodule

@@ sim/tb_modular_inverse_euclid.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for modular_inverse_euclid: streams key requests
// (p, q, e) and checks each private exponent and error flag against a local
// model of the extended Euclidean inverse. Depends on mie_pkg and the block.
module tb_modular_inverse_euclid;

    localparam int DRAIN_CYCLES = 8192;

    typedef struct {
        logic [mie_pkg::OUT_BITS-1:0] private_exp;
        logic                         div_error;
    } key_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // [31:0] prime_p, [63:32] prime_q, [127:64] public_exp
    logic [mie_pkg::IN_BITS-1:0]  s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // [63:0] private_exp
    logic [mie_pkg::OUT_BITS-1:0] m_axis_tdata;
    // [0] div_error
    logic                         m_axis_tuser;

    key_result_t pending_keys[$];
    int          mismatch_count = 0;
    int          requests_sent = 0;
    int          error_requests = 0;
    int          keys_checked = 0;
    int          burst_left = 0;
    int          hold_left = 0;

    modular_inverse_euclid #(
        .DATA_WIDTH(64)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Compute totient and Bezout-based inverse, all modulo 2^64
    function automatic key_result_t derive_private_exp(
        input logic [mie_pkg::P_BITS-1:0] p,
        input logic [mie_pkg::P_BITS-1:0] q,
        input logic [mie_pkg::E_BITS-1:0] e
    );
        key_result_t res;
        logic [63:0] totient, num, den, quo, rem, prev, cur, hold;
        int          step;
        totient = ({32'd0, p} - 64'd1) * ({32'd0, q} - 64'd1);
        if (e == '0 || totient == '0)
        begin
            res.private_exp = '0;
            res.div_error   = 1'b1;
            return res;
        end
        num  = totient;
        den  = e;
        prev = '0;
        cur  = 64'd1;
        for (step = 0; step < 128; step++)
        begin
            quo = num / den;
            rem = num - quo * den;
            if (rem == '0)
                break;
            num  = den;
            den  = rem;
            hold = cur;
            cur  = prev - quo * cur;
            prev = hold;
        end
        res.private_exp = (totient + cur) % totient;
        res.div_error   = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Drive one request in bursts with random gaps; queue its expected key
    task automatic send_request(input logic [mie_pkg::P_BITS-1:0] p,
                                input logic [mie_pkg::P_BITS-1:0] q,
                                input logic [mie_pkg::E_BITS-1:0] e);
        key_result_t want;
        int          gap;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 2000)
                                              : $urandom_range(1, 40);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {e, q, p};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        want = derive_private_exp(p, q, e);
        pending_keys.push_back(want);
        requests_sent++;
        if (want.div_error)
            error_requests++;
        burst_left--;
        @(negedge clk);
    endtask

    // Check every accepted result against the oldest pending key
    always @(posedge clk)
    begin
        key_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_keys.size() == 0)
                report_mismatch("result with nothing pending", m_axis_tdata, '0);
            else
            begin
                want = pending_keys.pop_front();
                keys_checked++;
                if (m_axis_tdata !== want.private_exp)
                    report_mismatch("private_exp", m_axis_tdata, want.private_exp);
                if (m_axis_tuser !== want.div_error)
                    report_mismatch("div_error", {63'd0, m_axis_tuser},
                                    {63'd0, want.div_error});
            end
        end
    end

    // Receiver: forced hold-off first, else a random stall mode redrawn each time rx_count wraps
    always @(negedge clk)
    begin
        int          rx_mode;
        int          rx_count;
        logic [15:0] stall_pattern;
        if (rx_count == 0)
        begin
            rx_mode       = $urandom_range(0, 3);
            stall_pattern = 16'($urandom);
        end
        rx_count = (rx_count + 1) % 64;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1:
                begin
                    m_axis_tready <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                end
                2: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Zero exponent and zero totient must flag an error
    task automatic test_error_cases();
        send_request(32'd61, 32'd53, 64'd0);
        send_request(32'd1, 32'd53, 64'd17);
        send_request(32'd61, 32'd1, 64'd17);
        send_request(32'd1, 32'd1, 64'd0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
    endtask

    // Field extremes, textbook keys and the loop's corner paths
    task automatic test_directed_keys();
        send_request(32'd61, 32'd53, 64'd17);
        send_request(32'd3, 32'd11, 64'd3);
        send_request(32'd7, 32'd11, 64'd6);                  // not coprime
        send_request(32'd7, 32'd11, 64'd60);                 // e equals totient
        send_request(32'd7, 32'd11, 64'd1);
        send_request(32'd5, 32'd7, 64'hFFFF_FFFF_FFFF_FFFF); // e above totient
        send_request(32'd0, 32'd0, 64'd5);                   // both primes wrap
        send_request(32'd0, 32'd3, 64'd65537);
        send_request(32'd2, 32'd2, 64'd3);                   // totient of one
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(32'hFFFF_FFFB, 32'hFFFF_FFEF, 64'd65537);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 64'h8000_0000_0000_0001);
        send_request(32'hAAAA_AAAB, 32'h5555_5555, 64'h5555_5555_AAAA_AAAB);
        send_request(32'd4294967291, 32'd4294967279, 64'd3);
        send_request(32'd101, 32'd103, 64'd10301);
    endtask

    // Hold the receiver off so the block fills and stalls its input
    task automatic test_output_backpressure();
        hold_left = 4000;
        send_request(32'd11, 32'd13, 64'd7);
        send_request(32'd17, 32'd19, 64'd5);
        send_request(32'd23, 32'd29, 64'd3);
        send_request(32'd31, 32'd37, 64'd7);
        send_request(32'd41, 32'd43, 64'd11);
    endtask

    // Mostly well-formed keys with random content, plus noise and errors
    task automatic test_random_keys(input int count);
        logic [mie_pkg::P_BITS-1:0] p, q;
        logic [mie_pkg::E_BITS-1:0] e;
        int                         sel;
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            p   = $urandom;
            q   = $urandom;
            e   = {$urandom, $urandom};
            if (sel < 60)
            begin
                p = p | 32'd3;
                q = q | 32'd3;
                case ($urandom_range(0, 3))
                    0: e = 64'd3;
                    1: e = 64'd65537;
                    2: e = {32'd0, $urandom} | 64'd1;
                    default: e = e | 64'd1;
                endcase
            end
            else if (sel < 75)
            begin
                p = $urandom_range(2, 200);
                q = $urandom_range(2, 200);
            end
            else if (sel < 92)
            begin
                // keep p, q and e fully random
            end
            else if (sel < 96)
                e = '0;
            else if (sel < 98)
                p = 32'd1;
            else
                q = 32'd1;
            send_request(p, q, e);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_error_cases();
        test_directed_keys();
        test_output_backpressure();
        test_random_keys(75);

        // Drop valid, wait for every pending key, then watch for strays
        s_axis_tvalid <= 1'b0;
        while (pending_keys.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d key requests (%0d with zero exponent or totient), %0d results",
                 requests_sent, error_requests, keys_checked);
        $display("Mismatches found: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
sv/mie_pkg.sv
sv/mie_divmul.sv
sv/mie_datapath.sv
sv/mie_ctrl.sv
sv/modular_inverse_euclid.sv
sim/tb_modular_inverse_euclid.sv
